FILE: rtl/last_note_priority_stack_top_macros.svh
`ifndef LAST_NOTE_PRIORITY_STACK_TOP_MACROS_SVH
`define LAST_NOTE_PRIORITY_STACK_TOP_MACROS_SVH

// checked on i_clk, off while i_rst_n is low
`define LNPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on i_clk at every edge, reset included
`define LNPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/lnps_pkg.sv
`default_nettype none

package lnps_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int TOP_W       = $clog2(STACK_DEPTH);
    localparam int NOTE_W      = 7;

    typedef logic [TOP_W-1:0]  t_top;
    typedef logic [NOTE_W-1:0] t_note;

    localparam t_top TOP_MAX = t_top'(STACK_DEPTH - 1);

    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic  gate;
        t_note note;
        logic  overflow;
    } t_lnps_res;

endpackage

`default_nettype wire

FILE: rtl/last_note_priority_stack_top.sv
// path: a press result is registered in the engine (r_res) and then in the output register;
// a release makes two walks down the slot memory before its result is registered
// (one slot per cycle through the single read port, whose read data is registered)
// flow: one event at a time; a new event is accepted only while the engine is idle,
// and the engine stays busy until the output register takes its result
// reset: synchronous active low, clears top_index and control; slot memory is not cleared
`default_nettype none

module last_note_priority_stack_top
    import lnps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_mode,
    input  wire t_note i_key_note,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_gate,
    output t_note      o_play_note,
    output logic       o_overflow
);

    logic      w_idle;
    logic      w_res_valid;
    t_lnps_res w_res;
    logic      w_res_take;

    logic      r_out_valid;
    t_lnps_res r_out;

    // output register free or draining this cycle
    assign w_res_take = !r_out_valid || i_out_ready;
    assign o_in_ready = w_idle;

    lnps_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && w_idle),
        .i_mode     (i_mode),
        .i_key_note (i_key_note),
        .o_idle     (w_idle),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_take (w_res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_take) begin
                r_out_valid <= w_res_valid;
                if (w_res_valid) begin
                    r_out <= w_res;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gate      = r_out.gate;
    assign o_play_note = r_out.note;
    assign o_overflow  = r_out.overflow;

endmodule

`default_nettype wire

FILE: rtl/lnps_engine.sv
`default_nettype none

`include "last_note_priority_stack_top_macros.svh"

module lnps_engine
    import lnps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire        i_mode,
    input  wire t_note i_key_note,
    output logic       o_idle,
    output logic       o_res_valid,
    output t_lnps_res  o_res,
    input  wire        i_res_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN1,
        S_SCAN2,
        S_EMIT
    } t_state;

    t_state    r_state;
    t_top      r_top;
    t_note     r_cur_note;
    t_note     r_key;
    t_top      r_rd_idx;
    t_top      r_cmp_idx;
    logic      r_cmp_vld;
    t_lnps_res r_res;

    t_note     mem [STACK_DEPTH];
    t_note     r_rd_data;

    logic      w_we;
    t_top      w_waddr;
    t_note     w_wdata;
    logic      w_re;
    logic      w_hit1;
    logic      w_hit2;
    logic      w_drained;

    // compare stage looks at the slot read in the previous cycle, held in r_rd_data
    assign w_hit1    = r_cmp_vld && (r_rd_data == r_key);
    assign w_hit2    = r_cmp_vld && (r_rd_data != '0);
    assign w_drained = (r_rd_idx == '0) && !r_cmp_vld;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_top + t_top'(1);
        w_wdata = i_key_note;
        w_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_we = i_start && (i_mode == MODE_PRESS) && (r_top != TOP_MAX);
            end
            S_SCAN1: begin
                if (w_hit1) begin
                    w_we    = 1'b1;
                    w_waddr = r_cmp_idx;
                    w_wdata = '0;
                end else begin
                    w_re = (r_rd_idx != '0);
                end
            end
            S_SCAN2: begin
                w_re = !w_hit2 && (r_rd_idx != '0);
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_mode == MODE_PRESS) begin
                            if (r_top == TOP_MAX) begin
                                r_res.gate     <= (r_top != '0);
                                r_res.note     <= (r_top != '0) ? r_cur_note : '0;
                                r_res.overflow <= 1'b1;
                            end else begin
                                r_top          <= r_top + t_top'(1);
                                r_cur_note     <= i_key_note;
                                r_res.gate     <= 1'b1;
                                r_res.note     <= i_key_note;
                                r_res.overflow <= 1'b0;
                            end
                            r_state <= S_EMIT;
                        end else begin
                            r_key     <= i_key_note;
                            r_rd_idx  <= r_top;
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_SCAN1;
                        end
                    end
                end
                S_SCAN1: begin
                    // clear topmost match, then rescan from the top
                    if (w_hit1 || w_drained) begin
                        r_rd_idx  <= r_top;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SCAN2;
                    end else begin
                        r_cmp_vld <= w_re;
                        r_cmp_idx <= r_rd_idx;
                        if (w_re) begin
                            r_rd_idx <= r_rd_idx - t_top'(1);
                        end
                    end
                end
                S_SCAN2: begin
                    if (w_hit2) begin
                        r_top          <= r_cmp_idx;
                        r_cur_note     <= r_rd_data;
                        r_res.gate     <= 1'b1;
                        r_res.note     <= r_rd_data;
                        r_res.overflow <= 1'b0;
                        r_cmp_vld      <= 1'b0;
                        r_state        <= S_EMIT;
                    end else if (w_drained) begin
                        r_top          <= '0;
                        r_res.gate     <= 1'b0;
                        r_res.note     <= '0;
                        r_res.overflow <= 1'b0;
                        r_state        <= S_EMIT;
                    end else begin
                        r_cmp_vld <= w_re;
                        r_cmp_idx <= r_rd_idx;
                        if (w_re) begin
                            r_rd_idx <= r_rd_idx - t_top'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    `LNPS_ASSERT_ALWAYS(a_reset_clears, (!i_rst_n) |=> (r_state == S_IDLE && r_top == '0), "reset did not clear stack control")
    `LNPS_ASSERT(a_full_push, (r_state == S_IDLE && i_start && i_mode == MODE_PRESS && r_top == TOP_MAX) |=> (r_top == TOP_MAX && r_res.overflow), "full push not dropped")
    `LNPS_ASSERT(a_gate_top, (r_state == S_EMIT) |-> (r_res.gate == (r_top != '0) && (r_res.gate || r_res.note == '0)), "gate disagrees with top")
    `LNPS_ASSERT(a_scan1_top, (r_state == S_SCAN1) |=> $stable(r_top), "top moved during match scan")
    `LNPS_ASSERT(a_clear_range, (w_we && r_state == S_SCAN1) |-> (r_cmp_idx != '0 && r_cmp_idx <= r_top), "cleared slot outside live range")

endmodule

`default_nettype wire

FILE: bench/last_note_priority_stack_top_tb.sv
`default_nettype none

module last_note_priority_stack_top_tb;
    import lnps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM     = 1120;
    localparam int QUIET_FROM   = 980;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 10;
    localparam int N_DIR        = 16;

    typedef struct packed {
        logic      mode;
        t_note     note;
        logic [6:0] reps;
        logic      typed;
        t_lnps_res res;
    } t_dir_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    logic  i_mode;
    t_note i_key_note;
    logic  o_out_valid;
    logic  i_out_ready;
    logic  o_gate;
    t_note o_play_note;
    logic  o_overflow;

    last_note_priority_stack_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_key_note  (i_key_note),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_gate      (o_gate),
        .o_play_note (o_play_note),
        .o_overflow  (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: held notes and the live top
    t_note     held_slots [STACK_DEPTH];
    t_top      live_top;
    int        deepest_top;

    t_lnps_res voice_q [$];
    t_note     pressed_q [$];
    t_dir_row  dir_rows [N_DIR];

    int  errors = 0;
    int  in_beats;
    int  out_beats = 0;
    int  n_overflow = 0;
    int  n_silent = 0;
    int  n_press;
    int  n_release;
    bit  quiet;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  ready_burst = 0;

    function automatic t_lnps_res next_voice(logic mode, t_note note);
        t_lnps_res r;
        int        i;
        bit        found;
        r.overflow = 1'b0;
        if (mode == MODE_PRESS) begin
            if (live_top == TOP_MAX) begin
                r.overflow = 1'b1;
            end else begin
                live_top = live_top + 1'b1;
                held_slots[live_top] = note;
            end
        end else begin
            found = 1'b0;
            for (i = int'(live_top); i > 0; i--) begin
                if (!found && held_slots[i] == note) begin
                    held_slots[i] = '0;
                    found = 1'b1;
                end
            end
            i = int'(live_top);
            while (i > 0 && held_slots[i] == '0)
                i--;
            live_top = t_top'(i);
        end
        if (int'(live_top) > deepest_top)
            deepest_top = int'(live_top);
        r.gate = (live_top != '0);
        r.note = r.gate ? held_slots[live_top] : '0;
        return r;
    endfunction

    task automatic offer_beat(logic mode, t_note note, logic typed, t_lnps_res res);
        int        gap;
        t_lnps_res want;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key_note <= note;
        do @(posedge i_clk); while (!o_in_ready);
        want = next_voice(mode, note);
        if (typed)
            want = res;
        voice_q.push_back(want);
        in_beats++;
        if (mode == MODE_PRESS)
            n_press++;
        else
            n_release++;
    endtask

    // receiver: random stall bursts, one long hold-off to back the block up
    always @(posedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && in_beats >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rdy = 1'b0;
        end else if (ready_burst > 0) begin
            ready_burst--;
            rdy = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            ready_burst = $urandom_range(1, 9) - 1;
            rdy = 1'b0;
        end
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        t_lnps_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_beats++;
            if (o_overflow)
                n_overflow++;
            if (!o_gate)
                n_silent++;
            if (voice_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat gate=%0b note=%0d overflow=%0b",
                         $time, o_gate, o_play_note, o_overflow);
            end else begin
                want = voice_q.pop_front();
                if (o_gate !== want.gate) begin
                    errors++;
                    if (errors < 30)
                        $display("%0t: gate expected %0b actual %0b",
                                 $time, want.gate, o_gate);
                end
                if (o_play_note !== want.note) begin
                    errors++;
                    if (errors < 30)
                        $display("%0t: play_note expected %0d actual %0d",
                                 $time, want.note, o_play_note);
                end
                if (o_overflow !== want.overflow) begin
                    errors++;
                    if (errors < 30)
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, o_overflow);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int    r;
        int    k;
        int    idx;
        int    press_pct;
        t_note note;
        logic  mode;

        in_beats = 0;
        n_press = 0; n_release = 0; quiet = 1'b0; deepest_top = 0;
        live_top = '0;
        foreach (held_slots[j])
            held_slots[j] = '0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_PRESS;
        i_key_note  <= '0;

        // mode, note, repeat, typed, expected {gate, note, overflow}
        dir_rows[0]  = '{MODE_RELEASE, 7'd10,  7'd1,  1'b1, '{1'b0, 7'd0,   1'b0}};
        dir_rows[1]  = '{MODE_PRESS,   7'd127, 7'd1,  1'b1, '{1'b1, 7'd127, 1'b0}};
        dir_rows[2]  = '{MODE_PRESS,   7'd0,   7'd1,  1'b1, '{1'b1, 7'd0,   1'b0}};
        // release of a note not held, scan skips the note-0 slot
        dir_rows[3]  = '{MODE_RELEASE, 7'd5,   7'd1,  1'b0, '0};
        dir_rows[4]  = '{MODE_RELEASE, 7'd127, 7'd1,  1'b0, '0};
        dir_rows[5]  = '{MODE_RELEASE, 7'd127, 7'd1,  1'b1, '{1'b0, 7'd0,   1'b0}};
        dir_rows[6]  = '{MODE_PRESS,   7'd1,   7'd1,  1'b1, '{1'b1, 7'd1,   1'b0}};
        dir_rows[7]  = '{MODE_PRESS,   7'd64,  7'd62, 1'b0, '0};
        // stack full: press dropped
        dir_rows[8]  = '{MODE_PRESS,   7'd99,  7'd1,  1'b1, '{1'b1, 7'd64,  1'b1}};
        dir_rows[9]  = '{MODE_RELEASE, 7'd64,  7'd1,  1'b0, '0};
        dir_rows[10] = '{MODE_PRESS,   7'd100, 7'd1,  1'b0, '0};
        dir_rows[11] = '{MODE_PRESS,   7'd33,  7'd1,  1'b1, '{1'b1, 7'd100, 1'b1}};
        dir_rows[12] = '{MODE_RELEASE, 7'd1,   7'd1,  1'b0, '0};
        dir_rows[13] = '{MODE_RELEASE, 7'd100, 7'd1,  1'b0, '0};
        dir_rows[14] = '{MODE_RELEASE, 7'd64,  7'd61, 1'b0, '0};
        dir_rows[15] = '{MODE_RELEASE, 7'd64,  7'd1,  1'b1, '{1'b0, 7'd0,   1'b0}};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIR; k++) begin
            for (r = 0; r < int'(dir_rows[k].reps); r++)
                offer_beat(dir_rows[k].mode, dir_rows[k].note,
                           dir_rows[k].typed && dir_rows[k].reps == 7'd1,
                           dir_rows[k].res);
        end

        // alternate fill-heavy and drain-heavy stretches
        for (k = 0; k < N_RANDOM; k++) begin
            quiet = (k >= QUIET_FROM);
            press_pct = ((k / 120) % 2 == 0) ? 75 : 30;
            r = $urandom_range(0, 99);
            if (r < press_pct) begin
                mode = MODE_PRESS;
                note = ($urandom_range(0, 39) == 0) ? t_note'(0)
                                                     : t_note'($urandom_range(0, 127));
                if (pressed_q.size() < STACK_DEPTH - 1)
                    pressed_q.push_back(note);
            end else if (r < 94 && pressed_q.size() > 0) begin
                mode = MODE_RELEASE;
                idx = $urandom_range(0, pressed_q.size() - 1);
                note = pressed_q[idx];
                pressed_q.delete(idx);
            end else begin
                mode = MODE_RELEASE;
                note = t_note'($urandom_range(0, 127));
            end
            offer_beat(mode, note, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (voice_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d events in (%0d presses, %0d releases), %0d results out",
                 in_beats, n_press, n_release, out_beats);
        $display("run: %0d dropped presses, %0d silent results, deepest stack %0d",
                 n_overflow, n_silent, deepest_top);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
